### design/frsq_pkg.sv
// Shared constants and rounding helpers for the reciprocal square root pipeline.
package frsq_pkg;

  localparam logic [31:0] MagicWord = 32'h5f3759d5;
  localparam logic [31:0] HalfBits  = 32'h3f000000;
  localparam logic [31:0] OneHalf3  = 32'h3fc00000;
  localparam logic [31:0] CanonNan  = 32'h7fc00000;
  localparam int unsigned MulStages = 3;
  localparam int unsigned AddStages = 3;

  typedef struct packed {
    logic nan;
    logic inf;
    logic zero;
    logic sign;
  } frsq_flags_t;

  function automatic logic [5:0] lzc48(logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [31:0] round_pack(logic sign, logic [10:0] e, logic [23:0] mant,
                                             logic g, logic st);
    logic        rnd;
    logic [24:0] mr;
    logic [33:0] s;
    rnd = g & (st | mant[0]);
    mr  = {1'b0, mant} + 25'(rnd);
    s   = {e - 11'd1, 23'b0} + {9'b0, mr};
    if (s[33:23] >= 11'd255) begin
      return {sign, 8'hff, 23'b0};
    end
    return {sign, s[30:0]};
  endfunction

endpackage

### design/frsq_if.sv
// Valid/ready channel interfaces for operands and results.
interface frsq_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] operand_bits;
  modport source (output valid, output operand_bits, input ready);
  modport sink   (input valid, input operand_bits, output ready);
endinterface

interface frsq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;
  modport source (output valid, output result_bits, input ready);
  modport sink   (input valid, input result_bits, output ready);
endinterface

### design/frsq_mul.sv
// Three-stage single-precision multiplier, round to nearest even.
module frsq_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        valid_o,
  output logic [31:0] res_o
);
  import frsq_pkg::*;

  logic [7:0]         ea, eb;
  logic [23:0]        ma, mb;
  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  frsq_flags_t        f1_d, f1_q, f2_q;
  logic signed [10:0] e1_d, e1_q;
  logic [47:0]        p_d, p_q;
  logic               v1_q, v2_q, v3_q;

  logic [5:0]         lz;
  logic signed [10:0] lz_s, rsh;
  logic [47:0]        q_d, q_q;
  logic               st_d, st_q;
  logic signed [10:0] e2_d, e2_q;
  logic [31:0]        res_d, res_q;

  always_comb begin
    ea     = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb     = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    ma     = {|a_i[30:23], a_i[22:0]};
    mb     = {|b_i[30:23], b_i[22:0]};
    a_nan  = (a_i[30:23] == 8'hff) && (a_i[22:0] != 23'd0);
    b_nan  = (b_i[30:23] == 8'hff) && (b_i[22:0] != 23'd0);
    a_inf  = (a_i[30:23] == 8'hff) && (a_i[22:0] == 23'd0);
    b_inf  = (b_i[30:23] == 8'hff) && (b_i[22:0] == 23'd0);
    a_zero = (a_i[30:0] == 31'd0);
    b_zero = (b_i[30:0] == 31'd0);
    f1_d.nan  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
    f1_d.inf  = a_inf | b_inf;
    f1_d.zero = a_zero | b_zero;
    f1_d.sign = a_i[31] ^ b_i[31];
    e1_d   = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd127;
    p_d    = ma * mb;
  end

  always_comb begin
    lz   = lzc48(p_q);
    lz_s = $signed({5'b0, lz});
    rsh  = -e1_q;
    q_d  = p_q;
    st_d = 1'b0;
    e2_d = 11'sd1;
    if (lz_s <= e1_q) begin
      q_d  = p_q << lz;
      e2_d = e1_q + 11'sd1 - lz_s;
    end else if (!e1_q[10]) begin
      q_d = p_q << e1_q[5:0];
    end else if (rsh >= 11'sd48) begin
      q_d  = 48'd0;
      st_d = |p_q;
    end else begin
      q_d  = p_q >> rsh[5:0];
      st_d = |(p_q << (6'd48 - rsh[5:0]));
    end
  end

  always_comb begin
    if (f2_q.nan) begin
      res_d = CanonNan;
    end else if (f2_q.inf) begin
      res_d = {f2_q.sign, 8'hff, 23'b0};
    end else if (f2_q.zero) begin
      res_d = {f2_q.sign, 31'b0};
    end else begin
      res_d = round_pack(f2_q.sign, e2_q, q_q[47:24], q_q[23], (|q_q[22:0]) | st_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_q  <= f1_d;
      e1_q  <= e1_d;
      p_q   <= p_d;
      f2_q  <= f1_q;
      q_q   <= q_d;
      st_q  <= st_d;
      e2_q  <= e2_d;
      res_q <= res_d;
    end
  end

  assign valid_o = v3_q;
  assign res_o   = res_q;
endmodule

### design/frsq_add.sv
// Three-stage single-precision adder, round to nearest even.
module frsq_add (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        valid_o,
  output logic [31:0] res_o
);
  import frsq_pkg::*;

  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, swap;
  logic [31:0] big, sml;
  logic [7:0]  eg, es, d;
  logic [26:0] mg, ms, al;
  frsq_flags_t f1_d, f1_q, f2_q;
  logic        sub_d, sub_q, zs_d, zs_q, zs2_q;
  logic [7:0]  eg_q, eg2_q;
  logic [26:0] mg_q, al_q;
  logic [27:0] sum_d, sum_q;
  logic [5:0]  lz_d, lz_q;
  logic [26:0] n;
  logic [10:0] e3;
  logic [31:0] res_d, res_q;
  logic        v1_q, v2_q, v3_q;

  always_comb begin
    a_nan  = (a_i[30:23] == 8'hff) && (a_i[22:0] != 23'd0);
    b_nan  = (b_i[30:23] == 8'hff) && (b_i[22:0] != 23'd0);
    a_inf  = (a_i[30:23] == 8'hff) && (a_i[22:0] == 23'd0);
    b_inf  = (b_i[30:23] == 8'hff) && (b_i[22:0] == 23'd0);
    a_zero = (a_i[30:0] == 31'd0);
    b_zero = (b_i[30:0] == 31'd0);
    swap   = b_i[30:0] > a_i[30:0];
    big    = swap ? b_i : a_i;
    sml    = swap ? a_i : b_i;
    eg     = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es     = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d      = eg - es;
    mg     = {|big[30:23], big[22:0], 3'b0};
    ms     = {|sml[30:23], sml[22:0], 3'b0};
    if (d >= 8'd27) begin
      al = {26'd0, |ms};
    end else begin
      al    = ms >> d;
      al[0] = al[0] | (|(ms << (5'd27 - d[4:0])));
    end
    sub_d     = a_i[31] ^ b_i[31];
    f1_d.nan  = a_nan | b_nan | (a_inf & b_inf & sub_d);
    f1_d.inf  = a_inf | b_inf;
    f1_d.zero = 1'b0;
    f1_d.sign = a_inf ? a_i[31] : (b_inf ? b_i[31] : big[31]);
    zs_d      = a_zero & b_zero & a_i[31] & b_i[31];
  end

  always_comb begin
    sum_d = sub_q ? ({1'b0, mg_q} - {1'b0, al_q}) : ({1'b0, mg_q} + {1'b0, al_q});
    lz_d  = lzc48({sum_d[26:0], 21'd0});
  end

  always_comb begin
    if (sum_q[27]) begin
      n  = {sum_q[27:2], sum_q[1] | sum_q[0]};
      e3 = {3'b0, eg2_q} + 11'd1;
    end else if ({5'b0, lz_q} <= {3'b0, eg2_q} - 11'd1) begin
      n  = sum_q[26:0] << lz_q;
      e3 = {3'b0, eg2_q} - {5'b0, lz_q};
    end else begin
      n  = sum_q[26:0] << (eg2_q - 8'd1);
      e3 = 11'd1;
    end
    if (f2_q.nan) begin
      res_d = CanonNan;
    end else if (f2_q.inf) begin
      res_d = {f2_q.sign, 8'hff, 23'b0};
    end else if (sum_q == 28'd0) begin
      res_d = {zs2_q, 31'b0};
    end else begin
      res_d = round_pack(f2_q.sign, e3, n[26:3], n[2], n[1] | n[0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_q  <= f1_d;
      sub_q <= sub_d;
      zs_q  <= zs_d;
      eg_q  <= eg;
      mg_q  <= mg;
      al_q  <= al;
      f2_q  <= f1_q;
      zs2_q <= zs_q;
      eg2_q <= eg_q;
      sum_q <= sum_d;
      lz_q  <= lz_d;
      res_q <= res_d;
    end
  end

  assign valid_o = v3_q;
  assign res_o   = res_q;
endmodule

### design/fast_inverse_square_root_unit.sv
// Pipelined fast reciprocal square root with one Newton step.
// Accepts one single-precision operand per cycle unless stalled and returns its
// approximate reciprocal square root: four multipliers and one adder, three
// register stages each, in series. A stalled output freezes the whole pipeline.
// Any NaN result comes out as the canonical quiet NaN 0x7FC00000.
module fast_inverse_square_root_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  frsq_in_if.sink    in_i,
  frsq_out_if.source out_o
);
  import frsq_pkg::*;

  localparam int unsigned YDepth = 3 * MulStages + AddStages;

  logic        en;
  logic [31:0] y0;
  logic [31:0] ydly_q [YDepth];
  logic        v0, v1, v2, v3, v4;
  logic [31:0] half, t1, t2, s, r;

  assign en        = !out_o.valid || out_o.ready;
  assign in_i.ready = en;
  assign y0        = MagicWord - {in_i.operand_bits[31], in_i.operand_bits[31:1]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      ydly_q[0] <= y0;
      for (int i = 1; i < YDepth; i++) begin
        ydly_q[i] <= ydly_q[i-1];
      end
    end
  end

  frsq_mul u_mul_half (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid),
    .a_i(HalfBits), .b_i(in_i.operand_bits), .valid_o(v0), .res_o(half)
  );

  frsq_mul u_mul_hy (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v0),
    .a_i(half), .b_i(ydly_q[MulStages-1]), .valid_o(v1), .res_o(t1)
  );

  frsq_mul u_mul_hyy (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1),
    .a_i(t1), .b_i(ydly_q[2*MulStages-1]), .valid_o(v2), .res_o(t2)
  );

  frsq_add u_sub (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2),
    .a_i(OneHalf3), .b_i({~t2[31], t2[30:0]}), .valid_o(v3), .res_o(s)
  );

  frsq_mul u_mul_out (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3),
    .a_i(ydly_q[YDepth-1]), .b_i(s), .valid_o(v4), .res_o(r)
  );

  assign out_o.valid       = v4;
  assign out_o.result_bits = r;
endmodule

### design/frsq_chk.sv
// Port-level checks for the reciprocal square root unit, bound to the top level.
module frsq_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_bits_i
);
  import frsq_pkg::*;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result transaction dropped while stalled");

  a_stall_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_bits_i))
    else $error("result changed while stalled");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input blocked without output stall");

  a_canon_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_bits_i[30:23] == 8'hff && out_bits_i[22:0] != 23'd0
      |-> out_bits_i == CanonNan)
    else $error("non-canonical NaN result");
endmodule

bind fast_inverse_square_root_unit frsq_chk u_frsq_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_bits_i  (out_o.result_bits)
);
